// File: design/lpht_pkg.sv
package lpht_pkg;

  localparam int CapacityDef  = 1024;
  localparam int ValueBitsDef = 32;

  localparam int KeyBits   = 64;
  localparam int ValueBits = 32;
  localparam int SizeBits  = 11;
  localparam int SlotBits  = 10;
  localparam int CfgIdxBits = 1;

  localparam logic [SizeBits-1:0] TableSizeRst  = SizeBits'(1024);
  localparam logic [SizeBits-1:0] MaxEntriesRst = SizeBits'(768);

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_SCAN = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_INSERTED    = 3'd0,
    STS_OVERWRITTEN = 3'd1,
    STS_FOUND       = 3'd2,
    STS_NOT_FOUND   = 3'd3,
    STS_FULL        = 3'd4,
    STS_SCAN_END    = 3'd5
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_TABLE_SIZE  = 1'b0,
    REG_MAX_ENTRIES = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_MOD,
    FSM_PROBE
  } fsm_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    logic [SizeBits-1:0]  start_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [KeyBits-1:0]   found_key;
    logic [ValueBits-1:0] found_value;
    logic [SlotBits-1:0]  slot;
    logic [SizeBits-1:0]  next_slot;
  } resp_t;

endpackage

// File: design/linear_probe_hash_table_core.sv
// Channel   Direction  Handshake                       Beat
// request   in         start / busy                    req_i (command, key, value, start_slot)
// result    out        resp_valid_o, one-cycle strobe  resp_o (status, key, value, slot, next)
// config    in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// After reset a clearing pass writes zero to every slot of the memory; busy is high meanwhile.
// Set and get: the shared bit-serial divider reduces the key modulo the table size, then slots
// are probed in turn from that remainder; the result strobe follows in the cycle after the last probe.
// Scan: slots are examined in turn from start_slot; other commands answer the cycle after start.
// Config is always ready. The result cannot be stalled; a new request is taken once busy drops.
module linear_probe_hash_table_core #(
  parameter int CAPACITY   = lpht_pkg::CapacityDef,
  parameter int VALUE_BITS = lpht_pkg::ValueBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  lpht_pkg::req_t                  req_i,
  output logic                            resp_valid_o,
  output lpht_pkg::resp_t                 resp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpht_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [lpht_pkg::SizeBits-1:0]   cfg_data_i
);
  import lpht_pkg::*;

  localparam int AddrW  = $clog2(CAPACITY);
  localparam int StoreW = (VALUE_BITS < ValueBits) ? VALUE_BITS : ValueBits;
  localparam int WordW  = 1 + KeyBits + StoreW;

  fsm_e                state_q, state_d;
  req_t                req_q;
  logic                load;
  logic [SizeBits-1:0] table_size_q, max_entries_q;
  logic [SizeBits-1:0] idx_q, idx_d;
  logic [SizeBits-1:0] cnt_q, cnt_d;
  logic [SizeBits-1:0] count_q, count_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  resp_t               resp_q, resp_d;
  logic                resp_valid_q, resp_valid_d;

  logic [SizeBits-1:0] eff;
  logic [SizeBits-1:0] idx_inc;

  logic [WordW-1:0]    mem [CAPACITY];
  logic [WordW-1:0]    rd_q;
  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [WordW-1:0]    wdata;
  logic [AddrW-1:0]    raddr;

  logic                rd_used;
  logic [KeyBits-1:0]  rd_key;
  logic [StoreW-1:0]   rd_val;

  logic                mod_start;
  logic                mod_done;
  logic [SizeBits-1:0] mod_rem;

  always_comb begin
    if (table_size_q == '0) begin
      eff = SizeBits'(1);
    end else if (int'(table_size_q) > CAPACITY) begin
      eff = SizeBits'(CAPACITY);
    end else begin
      eff = table_size_q;
    end
  end

  assign idx_inc = idx_q + 1'b1;
  assign rd_used = rd_q[WordW-1];
  assign rd_key  = rd_q[StoreW +: KeyBits];
  assign rd_val  = rd_q[StoreW-1:0];

  assign mod_start = (state_q == FSM_IDLE) && start &&
                     ((req_i.command == CMD_SET) || (req_i.command == CMD_GET));

  lpht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (req_i.key),
    .divisor_i  (eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d      = state_q;
    load         = 1'b0;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    count_d      = count_q;
    clr_d        = clr_q;
    resp_d       = resp_q;
    resp_valid_d = 1'b0;
    we           = 1'b0;
    waddr        = AddrW'(idx_q);
    wdata        = {1'b1, req_q.key, req_q.value[StoreW-1:0]};
    case (state_q)
      FSM_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(CAPACITY - 1)) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (start) begin
          load = 1'b1;
          case (req_i.command)
            CMD_SET, CMD_GET: begin
              state_d = FSM_MOD;
            end
            CMD_SCAN: begin
              if (req_i.start_slot >= eff) begin
                resp_valid_d     = 1'b1;
                resp_d           = '0;
                resp_d.status    = STS_SCAN_END;
                resp_d.next_slot = eff;
              end else begin
                idx_d   = req_i.start_slot;
                state_d = FSM_PROBE;
              end
            end
            default: begin
              resp_valid_d  = 1'b1;
              resp_d        = '0;
              resp_d.status = STS_NOT_FOUND;
            end
          endcase
        end
      end
      FSM_MOD: begin
        if (mod_done) begin
          idx_d   = mod_rem;
          cnt_d   = '0;
          state_d = FSM_PROBE;
        end
      end
      FSM_PROBE: begin
        if (req_q.command == CMD_SCAN) begin
          if (rd_used) begin
            resp_valid_d       = 1'b1;
            resp_d.status      = STS_FOUND;
            resp_d.found_key   = rd_key;
            resp_d.found_value = ValueBits'(rd_val);
            resp_d.slot        = idx_q[SlotBits-1:0];
            resp_d.next_slot   = idx_inc;
            state_d            = FSM_IDLE;
          end else if (idx_inc == eff) begin
            resp_valid_d     = 1'b1;
            resp_d           = '0;
            resp_d.status    = STS_SCAN_END;
            resp_d.next_slot = eff;
            state_d          = FSM_IDLE;
          end else begin
            idx_d = idx_inc;
          end
        end else if (!rd_used || (rd_key == req_q.key)) begin
          state_d      = FSM_IDLE;
          resp_valid_d = 1'b1;
          resp_d       = '0;
          if (req_q.command == CMD_GET) begin
            if (rd_used) begin
              resp_d.status      = STS_FOUND;
              resp_d.found_key   = rd_key;
              resp_d.found_value = ValueBits'(rd_val);
              resp_d.slot        = idx_q[SlotBits-1:0];
              resp_d.next_slot   = idx_inc;
            end else begin
              resp_d.status = STS_NOT_FOUND;
            end
          end else if (rd_used || (count_q < max_entries_q)) begin
            we                 = 1'b1;
            resp_d.status      = rd_used ? STS_OVERWRITTEN : STS_INSERTED;
            resp_d.found_key   = req_q.key;
            resp_d.found_value = ValueBits'(req_q.value[StoreW-1:0]);
            resp_d.slot        = idx_q[SlotBits-1:0];
            resp_d.next_slot   = idx_inc;
            if (!rd_used) begin
              count_d = count_q + 1'b1;
            end
          end else begin
            resp_d.status = STS_FULL;
          end
        end else if (cnt_q + 1'b1 == eff) begin
          state_d       = FSM_IDLE;
          resp_valid_d  = 1'b1;
          resp_d        = '0;
          resp_d.status = (req_q.command == CMD_GET) ? STS_NOT_FOUND : STS_FULL;
        end else begin
          idx_d = (idx_inc == eff) ? '0 : idx_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // read address follows the next probe index so data lands as the probe state checks it
  assign raddr = AddrW'(idx_d);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FSM_CLEAR;
      idx_q         <= '0;
      cnt_q         <= '0;
      count_q       <= '0;
      clr_q         <= '0;
      resp_valid_q  <= 1'b0;
      table_size_q  <= TableSizeRst;
      max_entries_q <= MaxEntriesRst;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      count_q      <= count_d;
      clr_q        <= clr_d;
      resp_valid_q <= resp_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TABLE_SIZE:  table_size_q  <= cfg_data_i;
          REG_MAX_ENTRIES: max_entries_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    resp_q <= resp_d;
    if (load) begin
      req_q <= req_i;
    end
  end

  assign busy         = (state_q != FSM_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign resp_valid_o = resp_valid_q;
  assign resp_o       = resp_q;

endmodule

// File: design/lpht_mod.sv
module lpht_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lpht_pkg::KeyBits-1:0]  dividend_i,
  input  logic [lpht_pkg::SizeBits-1:0] divisor_i,
  output logic                          done_o,
  output logic [lpht_pkg::SizeBits-1:0] rem_o
);
  import lpht_pkg::*;

  localparam int StepW = $clog2(KeyBits);

  logic                active_q, active_d;
  logic                done_q, done_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [KeyBits-1:0]  shreg_q, shreg_d;
  logic [SizeBits-1:0] div_q, div_d;
  logic [SizeBits-1:0] rem_q, rem_d;
  logic [SizeBits:0]   trial;
  logic [SizeBits:0]   diff;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, shreg_q[KeyBits-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    step_d   = step_q;
    shreg_d  = shreg_q;
    div_d    = div_q;
    rem_d    = rem_q;
    if (start_i) begin
      active_d = 1'b1;
      step_d   = '0;
      shreg_d  = dividend_i;
      div_d    = divisor_i;
      rem_d    = '0;
    end else if (active_q) begin
      shreg_d = {shreg_q[KeyBits-2:0], 1'b0};
      rem_d   = (trial >= {1'b0, div_q}) ? diff[SizeBits-1:0] : trial[SizeBits-1:0];
      step_d  = step_q + 1'b1;
      if (step_q == StepW'(KeyBits - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
